// File: rtl/dlca_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlca_pkg
// Shared types, constants and helpers of the DAG lowest-common-ancestor block.
// ----------------------------------------------------------------------------
package dlca_pkg;

	localparam int MAX_NODES   = 64;
	localparam int MAX_PARENTS = 2;
	localparam int ID_W        = $clog2(MAX_NODES + 1);
	localparam int IDX_W       = $clog2(MAX_NODES);
	localparam int CFG_W       = 7;

	typedef logic [ID_W-1:0]      node_id_t;
	typedef logic [MAX_NODES-1:0] node_set_t;
	typedef logic [MAX_PARENTS-1:0][ID_W-1:0] slots_t;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_EDGE  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [1:0] ST_LISTED  = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_CYC,
		S_ANC,
		S_LOW,
		S_EMIT,
		S_ONE
	} state_t;

	// Parent memory access of one cycle
	typedef struct packed {
		logic             clr;
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		slots_t           wr_data;
	} mem_req_t;

	// Set of in-range parents held in one entry
	function automatic node_set_t parent_bits(input slots_t s, input node_id_t n);
		node_set_t r;
		r = '0;
		for (int k = 0; k < MAX_PARENTS; k++) begin
			if (s[k] != '0 && s[k] <= n) begin
				r[IDX_W'(s[k] - node_id_t'(1))] = 1'b1;
			end
		end
		return r;
	endfunction

	// Bits of nodes 1..n
	function automatic node_set_t live_mask(input node_id_t n);
		node_set_t r;
		for (int k = 0; k < MAX_NODES; k++) begin
			r[k] = (k < int'(n));
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/dlca_parent_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dlca_parent_mem
// Parent-slot memory, one entry per node, with per-entry valid bits for clear.
// ----------------------------------------------------------------------------
module dlca_parent_mem
	import dlca_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mem_req_t req,
	output slots_t        rd_data
);

	slots_t                 mem [MAX_NODES];
	logic [MAX_NODES-1:0]   valid_q;
	slots_t                 rd_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	// entries not written since the last clear read as empty
	assign rd_data = rd_valid_q ? rd_q : slots_t'('0);

endmodule
`default_nettype wire

// File: rtl/dag_lowest_common_ancestors.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dag_lowest_common_ancestors
// Family graph store with lowest-common-ancestor queries.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* stream takes commands: clear graph, add edge, run query (s_tuser).
//    Opcode 3 is dropped. s_tready is high only while the sequencer is idle.
//  - m_* stream returns query results; status in m_tuser, m_tlast marks
//    the final result of a query. Clear and add edge return nothing.
//  - cfg_* writes node_count at any idle time; cfg_ready is always high.
// Timing:
//  - clear: valid bits cleared. add edge: parent-memory read, then write.
//  - query: passes over nodes 1..n, one parent-memory read per cycle
//    on the single read port. A cycle-check fixpoint (up to n+1 passes),
//    an ancestor fixpoint (up to n+1 passes) and one pass for the lowest
//    set, then a scan that emits at most one result per cycle, or a
//    single none/invalid result.
//  - a full output register holds while m_tready is low; the scan stalls on
//    it, new commands are still taken when the sequencer is idle.
// Reset: graph empty (valid bits cleared at once), node_count = 64.
// ----------------------------------------------------------------------------
module dag_lowest_common_ancestors
	import dlca_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [31:0]      s_tdata,   // parent[6:0] child[13:7] first[20:14] second[27:21]
	input  wire logic [1:0]       s_tuser,   // opcode[1:0]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [7:0]            m_tdata,   // ancestor_node[6:0]
	output logic [1:0]            m_tuser,   // status[1:0]
	output logic                  m_tlast,   // last_result
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CFG_W-1:0] cfg_data   // node_count[6:0]
);

	state_t           state_q, state_d;
	logic [CFG_W-1:0] node_count_q;
	node_id_t         n;
	logic             graph_inv_q;

	node_id_t         par_q, chd_q, a_q, b_q;
	node_id_t         cnt_q;           // pass read pointer 0..n
	logic             s1_vld_q;
	logic [IDX_W-1:0] s1_idx_q;
	logic             changed_q;
	node_set_t        set_a_q, set_b_q, aux_q;   // aux: settled / parents of common
	node_set_t        lowest_q;
	logic [IDX_W-1:0] scan_q;
	logic [1:0]       res_st_q;        // status of a single none/invalid result

	logic             m_valid_q, m_last_q;
	logic [1:0]       m_status_q;
	node_id_t         m_node_q;

	mem_req_t         req;
	slots_t           rdata;
	node_set_t        pbits;

	node_id_t         in_par, in_chd, in_a, in_b;
	logic             accept, out_free, pass_end, m_load;

	assign in_par   = s_tdata[6:0];
	assign in_chd   = s_tdata[13:7];
	assign in_a     = s_tdata[20:14];
	assign in_b     = s_tdata[27:21];
	assign n        = (node_count_q > CFG_W'(MAX_NODES)) ? node_id_t'(MAX_NODES)
	                                                     : node_id_t'(node_count_q);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free = !m_valid_q || m_tready;
	assign pass_end = (cnt_q == n) && !s1_vld_q;
	assign pbits    = parent_bits(rdata, n);
	// output register loads a new result
	assign m_load   = out_free && ((state_q == S_ONE) ||
	                               (state_q == S_EMIT && lowest_q[scan_q]));

	dlca_parent_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory requests
	always_comb begin
		state_d     = state_q;
		req         = '0;
		req.rd_addr = IDX_W'(cnt_q);
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					priority if (s_tuser == OP_CLEAR) begin
						req.clr = 1'b1;
					end else if (s_tuser == OP_EDGE) begin
						if (in_par != '0 && in_par <= n && in_chd != '0 && in_chd <= n) begin
							req.rd_en   = 1'b1;
							req.rd_addr = IDX_W'(in_chd - node_id_t'(1));
							state_d     = S_EDGE;
						end
					end else if (s_tuser == OP_QUERY) begin
						state_d = graph_inv_q ? S_ONE : S_CYC;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_EDGE: begin
				state_d     = S_IDLE;
				req.wr_addr = IDX_W'(chd_q - node_id_t'(1));
				req.wr_data = rdata;
				for (int k = MAX_PARENTS - 1; k >= 0; k--) begin
					if (rdata[k] == '0) begin
						req.wr_en   = 1'b1;
						req.wr_data = rdata;
						req.wr_data[k] = par_q;
					end
				end
				// restore priority: lowest empty slot wins
				if (req.wr_en) begin
					req.wr_data = rdata;
					begin : first_empty
						logic done;
						done = 1'b0;
						for (int k = 0; k < MAX_PARENTS; k++) begin
							if (!done && rdata[k] == '0) begin
								req.wr_data[k] = par_q;
								done = 1'b1;
							end
						end
					end
				end
			end
			S_CYC, S_ANC, S_LOW: begin
				req.rd_en = (cnt_q != n);
				if (pass_end && !(changed_q && state_q != S_LOW)) begin
					unique case (state_q)
						S_CYC: begin
							if ((aux_q & live_mask(n)) != live_mask(n)) begin
								state_d = S_ONE;
							end else if (a_q == '0 || a_q > n || b_q == '0 || b_q > n) begin
								state_d = S_ONE;
							end else begin
								state_d = S_ANC;
							end
						end
						S_ANC:   state_d = S_LOW;
						default: state_d = ((set_a_q & set_b_q & ~aux_q) == '0) ? S_ONE : S_EMIT;
					endcase
				end
			end
			S_EMIT: begin
				if (lowest_q == '0) begin
					state_d = S_IDLE;
				end
			end
			S_ONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(MAX_NODES);
			graph_inv_q  <= 1'b0;
			s1_vld_q     <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			if (m_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			s1_vld_q <= req.rd_en && (state_q != S_IDLE);
			unique case (state_q)
				S_IDLE: begin
					if (accept && s_tuser == OP_CLEAR) begin
						graph_inv_q <= 1'b0;
					end
				end
				S_EDGE: begin
					if (!req.wr_en) begin
						graph_inv_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload and pass registers
	always_ff @(posedge clk) begin
		s1_idx_q <= IDX_W'(cnt_q);
		if (req.rd_en && state_q != S_IDLE) begin
			cnt_q <= cnt_q + node_id_t'(1);
		end
		unique case (state_q)
			S_IDLE: begin
				par_q     <= in_par;
				chd_q     <= in_chd;
				a_q       <= in_a;
				b_q       <= in_b;
				cnt_q     <= '0;
				changed_q <= 1'b0;
				aux_q     <= '0;
				res_st_q  <= ST_INVALID;
			end
			S_CYC, S_ANC, S_LOW: begin
				if (s1_vld_q) begin
					if (state_q == S_CYC) begin
						if ((pbits & ~aux_q) == '0 && !aux_q[s1_idx_q]) begin
							aux_q[s1_idx_q] <= 1'b1;
							changed_q       <= 1'b1;
						end
					end else if (state_q == S_ANC) begin
						if ((set_a_q[s1_idx_q] && (pbits & ~set_a_q) != '0) ||
						    (set_b_q[s1_idx_q] && (pbits & ~set_b_q) != '0)) begin
							changed_q <= 1'b1;
						end
						if (set_a_q[s1_idx_q]) set_a_q <= set_a_q | pbits;
						if (set_b_q[s1_idx_q]) set_b_q <= set_b_q | pbits;
					end else begin
						if (set_a_q[s1_idx_q] && set_b_q[s1_idx_q]) begin
							aux_q <= aux_q | pbits;
						end
					end
				end
				if (pass_end) begin
					cnt_q     <= '0;
					changed_q <= 1'b0;
					if (state_d != state_q) begin
						res_st_q <= (state_q == S_CYC &&
						             (aux_q & live_mask(n)) != live_mask(n))
						            ? ST_INVALID : ST_NONE;
						unique case (state_q)
							S_CYC: begin
								if (a_q != '0 && a_q <= n && b_q != '0 && b_q <= n) begin
									set_a_q <= node_set_t'(1) << IDX_W'(a_q - node_id_t'(1));
									set_b_q <= node_set_t'(1) << IDX_W'(b_q - node_id_t'(1));
								end else begin
									set_a_q <= '0;
									set_b_q <= '0;
								end
								aux_q <= '0;
							end
							S_ANC: aux_q <= '0;
							default: begin
								lowest_q <= set_a_q & set_b_q & ~aux_q;
								scan_q   <= '0;
							end
						endcase
					end
				end
			end
			S_EMIT: begin
				if (!lowest_q[scan_q] || out_free) begin
					scan_q <= scan_q + IDX_W'(1);
				end
				if (lowest_q[scan_q] && out_free) begin
					lowest_q[scan_q] <= 1'b0;
					m_status_q <= ST_LISTED;
					m_node_q   <= node_id_t'(scan_q) + node_id_t'(1);
					m_last_q   <= ((lowest_q & ~(node_set_t'(1) << scan_q)) == '0);
				end
			end
			S_ONE: begin
				if (out_free) begin
					m_status_q <= res_st_q;
					m_node_q   <= '0;
					m_last_q   <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = 8'(m_node_q);
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_single_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_LISTED |-> m_tlast && m_tdata == 8'd0)
		else $error("none/invalid result without last or with node id");
	a_listed_node: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_LISTED |-> m_tdata != 8'd0)
		else $error("listed result with node id zero");
	a_idle_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !s1_vld_q)
		else $error("memory read in flight while idle");
`endif

endmodule
`default_nettype wire
